>>> rtl/s2i_pkg.sv
package s2i_pkg;

  // Default width of the saturating byte counter.
  localparam int OFFSET_BITS_DEF = 16;

  // Configuration port.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Values of base_select.
  localparam logic [7:0] BSEL_AUTO  = 8'd0;
  localparam logic [7:0] BSEL_BIN   = 8'd2;
  localparam logic [7:0] BSEL_DEC   = 8'd10;
  localparam logic [7:0] BSEL_HEX   = 8'd16;
  localparam logic [7:0] BSEL_RESET = BSEL_DEC;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Largest offset that the result field can carry.
  localparam logic [15:0] OFFSET_OUT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_PLUS   = 3'd1,
    PH_BODY   = 3'd2,
    PH_HEXX   = 3'd3,
    PH_AUTO0  = 3'd4,
    PH_DIGITS = 3'd5,
    PH_IGNORE = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    AB_DEC = 2'd0,
    AB_BIN = 2'd1,
    AB_HEX = 2'd2
  } abase_t;

endpackage

>>> rtl/s2i_digit_mac.sv
module s2i_digit_mac (
  input  logic [7:0]      ch,
  input  s2i_pkg::abase_t base,
  input  logic [63:0]     acc,
  output logic            is_digit,
  output logic [63:0]     acc_next
);

  logic [3:0]  digit;
  logic [63:0] digit_ext;

  // Classify the byte in the given base and find its digit value.
  always_comb begin
    is_digit = 1'b0;
    digit    = '0;
    if (base == s2i_pkg::AB_BIN) begin
      if (ch == s2i_pkg::CH_ZERO || ch == s2i_pkg::CH_ONE) begin
        is_digit = 1'b1;
        digit    = ch[3:0];
      end
    end else if (ch inside {[s2i_pkg::CH_ZERO:s2i_pkg::CH_NINE]}) begin
      is_digit = 1'b1;
      digit    = ch[3:0];
    end else if (base == s2i_pkg::AB_HEX &&
                 (ch inside {[s2i_pkg::CH_LA:s2i_pkg::CH_LF],
                             [s2i_pkg::CH_UA:s2i_pkg::CH_UF]})) begin
      // Letters a..f and A..F have low nibbles 1..6.
      is_digit = 1'b1;
      digit    = ch[3:0] + 4'd9;
    end
  end

  assign digit_ext = {60'd0, digit};

  // Multiply by a constant base with shifts, wrapping modulo 2^64.
  always_comb begin
    case (base)
      s2i_pkg::AB_BIN: acc_next = {acc[62:0], 1'b0} + digit_ext;
      s2i_pkg::AB_HEX: acc_next = {acc[59:0], 4'd0} + digit_ext;
      default:         acc_next = {acc[60:0], 3'd0} + {acc[62:0], 1'b0} + digit_ext;
    endcase
  end

endmodule

>>> rtl/string_to_int64_parser.sv
// A result is registered on the master side in the cycle after the byte that ends the parse.
// Throughput: one byte per cycle; the input stalls only while a finished result waits unread.
// The per-byte work is one pass of phase decode and a shift-and-add accumulate of 64 bits.
// Reset (rst, synchronous, active high) sets base_select to decimal (10), returns the parser
// to the whitespace phase with a cleared accumulator, sign and byte counter, and empties
// the result register.
module string_to_int64_parser #(
  parameter int OFFSET_BITS = s2i_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream of string bytes.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] ch
  // Result stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [79:0]                        m_tdata,   // [63:0] value, [79:64] end_offset
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [s2i_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [s2i_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [s2i_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  // Width used to compare the counter against the largest reportable offset.
  localparam int CW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

  // Configuration register. There is only one, so bit 2 of the byte address
  // separates it from the unused space above it.
  logic [7:0] base_select;

  // Per-string parser state.
  s2i_pkg::phase_t phase, phase_next;
  s2i_pkg::abase_t active_base, active_base_next;
  logic            negative_flag, negative_flag_next;
  logic [63:0]     accumulator, accumulator_next;
  logic [OFFSET_BITS-1:0] byte_count, byte_count_next;

  // Decode outputs for the byte at the input.
  logic            s_accept;
  logic            body_start;
  logic            do_digit;
  logic            emit_parsed;
  logic            emit_zero;
  logic            emit;
  logic            clear;
  s2i_pkg::abase_t digit_base;
  logic            mac_is_digit;
  logic [63:0]     mac_acc;
  logic [7:0]      ch;
  logic            is_space;
  logic            is_x;
  logic [CW-1:0]   count_wide;
  logic [15:0]     offset_sat;
  logic [63:0]     value_out;
  logic [15:0]     offset_out;

  // ---------------------------------------------------------------------------
  // Configuration port. Every transfer completes in its access cycle.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= s2i_pkg::BSEL_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      base_select <= pwdata[7:0];
    end
  end

  assign prdata = paddr[2] ? '0 : {{(s2i_pkg::APB_DATA_BITS-8){1'b0}}, base_select};

  // ---------------------------------------------------------------------------
  // Handshake. The result register holds one item; a new byte is taken whenever
  // that register is empty or is being emptied in the same cycle, so bytes flow
  // back to back while the downstream side keeps up.
  // ---------------------------------------------------------------------------
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  assign ch       = s_tdata;
  assign is_space = (ch == s2i_pkg::CH_SPACE) || (ch inside {[s2i_pkg::CH_TAB:s2i_pkg::CH_CR]});
  assign is_x     = (ch == s2i_pkg::CH_LX) || (ch == s2i_pkg::CH_UX);

  // Digit classification and accumulate step, in the base chosen below.
  s2i_digit_mac u_mac (
    .ch       (ch),
    .base     (digit_base),
    .acc      (accumulator),
    .is_digit (mac_is_digit),
    .acc_next (mac_acc)
  );

  // ---------------------------------------------------------------------------
  // Next-state decode for one byte.
  // The whitespace, plus and body phases handle an optional sign; once the
  // body starts, base_select is sampled and picks a digit run, a hex prefix
  // check, the auto-detect path, or a zero result for an unsupported value. The
  // first byte that is not a digit ends the parse and produces the result; a NUL
  // also ends the string, and bytes after the result are dropped until that NUL.
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_next         = phase;
    active_base_next   = active_base;
    negative_flag_next = negative_flag;
    accumulator_next   = accumulator;
    body_start         = 1'b0;
    do_digit           = 1'b0;
    emit_parsed        = 1'b0;
    emit_zero          = 1'b0;
    clear              = 1'b0;
    digit_base         = active_base;

    case (phase)
      s2i_pkg::PH_WS: begin
        if (is_space) begin
          phase_next = phase;
        end else if (ch == s2i_pkg::CH_PLUS) begin
          phase_next = s2i_pkg::PH_PLUS;
        end else if (ch == s2i_pkg::CH_MINUS) begin
          negative_flag_next = 1'b1;
          phase_next         = s2i_pkg::PH_BODY;
        end else begin
          body_start = 1'b1;
        end
      end
      s2i_pkg::PH_PLUS: begin
        // A minus may still follow a plus, but not the other way round.
        if (ch == s2i_pkg::CH_MINUS) begin
          negative_flag_next = 1'b1;
          phase_next         = s2i_pkg::PH_BODY;
        end else begin
          body_start = 1'b1;
        end
      end
      s2i_pkg::PH_BODY: begin
        body_start = 1'b1;
      end
      s2i_pkg::PH_HEXX: begin
        if (is_x) begin
          active_base_next = s2i_pkg::AB_HEX;
          phase_next       = s2i_pkg::PH_DIGITS;
        end else begin
          emit_zero = 1'b1;
        end
      end
      s2i_pkg::PH_AUTO0: begin
        // A leading zero without x means binary, and the zero was a digit.
        if (is_x) begin
          active_base_next = s2i_pkg::AB_HEX;
          phase_next       = s2i_pkg::PH_DIGITS;
        end else begin
          active_base_next = s2i_pkg::AB_BIN;
          digit_base       = s2i_pkg::AB_BIN;
          do_digit         = 1'b1;
        end
      end
      s2i_pkg::PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: begin
        // Waiting for the terminator after the result has gone out.
        if (ch == s2i_pkg::CH_NUL) begin
          clear = 1'b1;
        end
      end
    endcase

    if (body_start) begin
      case (base_select)
        s2i_pkg::BSEL_AUTO: begin
          if (ch == s2i_pkg::CH_ZERO) begin
            phase_next = s2i_pkg::PH_AUTO0;
          end else begin
            active_base_next = s2i_pkg::AB_DEC;
            digit_base       = s2i_pkg::AB_DEC;
            do_digit         = 1'b1;
          end
        end
        s2i_pkg::BSEL_BIN: begin
          active_base_next = s2i_pkg::AB_BIN;
          digit_base       = s2i_pkg::AB_BIN;
          do_digit         = 1'b1;
        end
        s2i_pkg::BSEL_DEC: begin
          active_base_next = s2i_pkg::AB_DEC;
          digit_base       = s2i_pkg::AB_DEC;
          do_digit         = 1'b1;
        end
        s2i_pkg::BSEL_HEX: begin
          // Hex requires the 0x prefix.
          if (ch == s2i_pkg::CH_ZERO) begin
            phase_next = s2i_pkg::PH_HEXX;
          end else begin
            emit_zero = 1'b1;
          end
        end
        default: begin
          // An unsupported base reports zero at offset zero.
          emit_zero = 1'b1;
        end
      endcase
    end

    if (do_digit) begin
      if (mac_is_digit) begin
        accumulator_next = mac_acc;
        phase_next       = s2i_pkg::PH_DIGITS;
      end else begin
        emit_parsed = 1'b1;
      end
    end

    emit = emit_parsed || emit_zero;
    if (emit) begin
      if (ch == s2i_pkg::CH_NUL) begin
        clear = 1'b1;
      end else begin
        phase_next = s2i_pkg::PH_IGNORE;
      end
    end

    if (clear) begin
      phase_next         = s2i_pkg::PH_WS;
      active_base_next   = s2i_pkg::AB_DEC;
      negative_flag_next = 1'b0;
      accumulator_next   = '0;
    end
  end

  // The counter saturates at its all-ones value and restarts with each string.
  always_comb begin
    if (clear) begin
      byte_count_next = '0;
    end else if (byte_count != {OFFSET_BITS{1'b1}}) begin
      byte_count_next = byte_count + 1'b1;
    end else begin
      byte_count_next = byte_count;
    end
  end

  // Offset of the current byte, clipped to the 16-bit result field.
  assign count_wide = CW'(byte_count);
  assign offset_sat = (count_wide > CW'(s2i_pkg::OFFSET_OUT_MAX)) ? s2i_pkg::OFFSET_OUT_MAX
                                                                   : count_wide[15:0];

  // The parsed value is negated modulo 2^64 when a minus sign was seen.
  assign value_out  = emit_parsed ? (negative_flag ? (64'd0 - accumulator) : accumulator)
                                  : 64'd0;
  assign offset_out = emit_parsed ? offset_sat : 16'd0;

  // ---------------------------------------------------------------------------
  // State registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= s2i_pkg::PH_WS;
      active_base   <= s2i_pkg::AB_DEC;
      negative_flag <= 1'b0;
      accumulator   <= '0;
      byte_count    <= '0;
    end else if (s_accept) begin
      phase         <= phase_next;
      active_base   <= active_base_next;
      negative_flag <= negative_flag_next;
      accumulator   <= accumulator_next;
      byte_count    <= byte_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It is refilled in the same cycle that its item is taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && emit) begin
      m_tdata <= {offset_out, value_out};
    end
  end

`ifndef ASSERT_OFF
  // A result that is still waiting must hold the input back.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while the result register was full");

  // A new result only ever follows an accepted byte.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(s_accept))
    else $error("result appeared without an accepted byte");

  // A terminator always returns the parser to a clean start.
  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tdata == s2i_pkg::CH_NUL) |=>
      (phase == s2i_pkg::PH_WS && byte_count == '0 && accumulator == '0 && !negative_flag))
    else $error("terminator did not clear the parser state");

  // Bytes after a result are dropped: the ignore phase holds until a terminator.
  a_ignore_holds: assert property (@(posedge clk) disable iff (rst)
    (s_accept && phase == s2i_pkg::PH_IGNORE && s_tdata != s2i_pkg::CH_NUL) |=>
      (phase == s2i_pkg::PH_IGNORE && !m_tvalid))
    else $error("parser left the ignore phase before the terminator");
`endif

endmodule

>>> tb/sv/string_to_int64_parser_tb.sv
module string_to_int64_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import s2i_pkg::*;

  // The only register, base_select, sits at byte address 0.
  localparam logic [APB_ADDR_BITS-1:0] REG_BASE_SELECT = '0;

  // One parsed number as it leaves the block on the result stream.
  typedef struct packed {
    logic [63:0] value;
    logic [15:0] end_offset;
  } parsed_number_t;

  // Bases for the random phases that fall outside 0, 2, 10 and 16.
  localparam logic [7:0] ODD_BASES [5] = '{8'd1, 8'd8, 8'd17, 8'd36, 8'd255};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata = '0;    // [7:0] ch
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [79:0]              m_tdata;         // [63:0] value, [79:64] end_offset
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  string_to_int64_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Our own copy of the parser. cfg_base mirrors base_select; the rest is the
  // per-string state that the block keeps between bytes.
  logic [7:0]     cfg_base = BSEL_RESET;
  phase_t         ph = PH_WS;
  logic           neg = 1'b0;
  abase_t         ab = AB_DEC;
  logic [63:0]    acc = '0;
  logic [15:0]    nbytes = '0;

  // Numbers that the parser must still deliver, oldest first.
  parsed_number_t parsed_numbers[$];

  int errors = 0;
  // Bytes accepted while a string was still being parsed; trailing bytes that
  // the block skips on its way to the terminator are not counted.
  int live_bytes = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int rx_wait = 0;

  function automatic void clear_string();
    ph = PH_WS;
    neg = 1'b0;
    ab = AB_DEC;
    acc = '0;
    nbytes = '0;
  endfunction

  // A result closes the string at once when the closing byte is the NUL;
  // otherwise the rest of the string is skipped up to its NUL.
  function automatic void emit_number(input logic [7:0] c, input logic [63:0] v,
                                      input logic [15:0] off);
    parsed_number_t n;
    n.value = v;
    n.end_offset = off;
    parsed_numbers.push_back(n);
    if (c == CH_NUL) begin
      clear_string();
    end else begin
      ph = PH_IGNORE;
    end
  endfunction

  function automatic int digit_value(input logic [7:0] c);
    if (ab == AB_BIN) begin
      if (c == CH_ZERO || c == CH_ONE) return c - CH_ZERO;
      return -1;
    end
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (ab == AB_HEX) begin
      if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
      if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
    end
    return -1;
  endfunction

  // Either folds a digit into the accumulator (wrapping at 64 bits) or ends
  // the parse with the signed value and the offset of the closing byte.
  function automatic void digit_step(input logic [7:0] c, input logic [15:0] off);
    int          d;
    logic [63:0] radix;
    d = digit_value(c);
    if (d < 0) begin
      emit_number(c, neg ? 64'd0 - acc : acc, off);
    end else begin
      radix = (ab == AB_BIN) ? 64'd2 : (ab == AB_HEX) ? 64'd16 : 64'd10;
      acc = acc * radix + 64'(d);
      ph = PH_DIGITS;
    end
  endfunction

  // First byte after whitespace and sign: this is where the base is latched.
  function automatic void start_body(input logic [7:0] c, input logic [15:0] off);
    case (cfg_base)
      BSEL_AUTO: begin
        if (c == CH_ZERO) begin
          ph = PH_AUTO0;
        end else begin
          ab = AB_DEC;
          digit_step(c, off);
        end
      end
      BSEL_BIN: begin
        ab = AB_BIN;
        digit_step(c, off);
      end
      BSEL_DEC: begin
        ab = AB_DEC;
        digit_step(c, off);
      end
      BSEL_HEX: begin
        if (c == CH_ZERO) begin
          ph = PH_HEXX;
        end else begin
          emit_number(c, 64'd0, 16'd0);
        end
      end
      default: emit_number(c, 64'd0, 16'd0);
    endcase
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Advances the parser by one accepted byte and queues any number it yields.
  function automatic void parse_byte(input logic [7:0] c);
    logic [15:0] off;
    off = nbytes;
    if (nbytes != OFFSET_OUT_MAX) nbytes++;
    case (ph)
      PH_WS: begin
        if (is_space(c)) begin
        end else if (c == CH_PLUS) begin
          ph = PH_PLUS;
        end else if (c == CH_MINUS) begin
          neg = 1'b1;
          ph = PH_BODY;
        end else begin
          start_body(c, off);
        end
      end
      PH_PLUS: begin
        if (c == CH_MINUS) begin
          neg = 1'b1;
          ph = PH_BODY;
        end else begin
          start_body(c, off);
        end
      end
      PH_BODY: start_body(c, off);
      PH_HEXX: begin
        if (c == CH_LX || c == CH_UX) begin
          ab = AB_HEX;
          ph = PH_DIGITS;
        end else begin
          emit_number(c, 64'd0, 16'd0);
        end
      end
      PH_AUTO0: begin
        if (c == CH_LX || c == CH_UX) begin
          ab = AB_HEX;
          ph = PH_DIGITS;
        end else begin
          // The leading zero was already a binary digit worth nothing.
          ab = AB_BIN;
          digit_step(c, off);
        end
      end
      PH_DIGITS: digit_step(c, off);
      default: begin
        if (c == CH_NUL) clear_string();
      end
    endcase
  endfunction

  // Watches both streams at every rising edge. A result always belongs to an
  // earlier byte than one accepted at the same edge, so results are checked
  // before the byte of this edge enters the parser.
  always @(posedge clk) begin
    parsed_number_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (parsed_numbers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %h offset %0d",
                   $realtime, m_tdata[63:0], m_tdata[79:64]);
          errors++;
        end else begin
          want = parsed_numbers.pop_front();
          if (m_tdata[63:0] !== want.value) begin
            $display("%0t: value mismatch, expected %h, actual %h",
                     $realtime, want.value, m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[79:64] !== want.end_offset) begin
            $display("%0t: end_offset mismatch, expected %0d, actual %0d",
                     $realtime, want.end_offset, m_tdata[79:64]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (ph != PH_IGNORE) live_bytes++;
        parse_byte(s_tdata);
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // Result-side back-pressure: m_tready drops for random stretches while
  // stalls are enabled and stays high otherwise.
  always @(posedge clk) begin
    if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait--;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
      m_tready <= 1'b0;
      rx_wait = pick_gap() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Presents one byte and returns at the edge where its transfer happens.
  // tvalid is left high so that back-to-back bytes need no extra step.
  task automatic send_byte(input logic [7:0] ch);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input bit terminate);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    if (terminate) send_byte(CH_NUL);
  endtask

  // Holds the input until every queued number has come out and then lets the
  // parser settle, since a byte that yields nothing may still be in flight.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (parsed_numbers.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes base_select with an idle parser, then updates our copy.
  task automatic write_base(input logic [7:0] base);
    wait_for_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_BASE_SELECT;
    pwdata <= APB_DATA_BITS'(base);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_base = base;
  endtask

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? CH_SPACE : CH_TAB + 8'(r - 1);
  endfunction

  function automatic logic [7:0] rand_digit(input int radix);
    int d;
    d = $urandom_range(0, radix - 1);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] rand_junk();
    return 8'($urandom_range(1, 255));
  endfunction

  // Mostly well-formed numbers for the current base with random whitespace,
  // signs, digits and tail; the rest are strings of arbitrary bytes. Long
  // digit runs make the accumulator wrap.
  task automatic send_random_string();
    logic [7:0] text[$];
    int         radix;
    int         ndig;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 8)) text.push_back(rand_junk());
    end else begin
      repeat (($urandom_range(0, 99) < 30) ? $urandom_range(1, 3) : 0)
        text.push_back(rand_space());
      case ($urandom_range(0, 9))
        5, 6: text.push_back(CH_MINUS);
        7: text.push_back(CH_PLUS);
        8: begin
          text.push_back(CH_PLUS);
          text.push_back(CH_MINUS);
        end
        9: begin
          // A sign followed by a second sign or whitespace. Apart from plus then minus,
          // none is allowed: minus before plus, a double sign, or whitespace after it.
          text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          case ($urandom_range(0, 2))
            0: text.push_back(CH_PLUS);
            1: text.push_back(CH_MINUS);
            default: text.push_back(CH_SPACE);
          endcase
        end
        default: ;
      endcase
      radix = 10;
      case (cfg_base)
        BSEL_AUTO: begin
          case ($urandom_range(0, 2))
            0: begin
              text.push_back(CH_ZERO);
              text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
              radix = 16;
            end
            1: begin
              text.push_back(CH_ZERO);
              radix = 2;
            end
            default: radix = 10;
          endcase
        end
        BSEL_BIN: radix = 2;
        BSEL_HEX: begin
          radix = 16;
          // Now and then the prefix is left out, which must yield zero.
          if ($urandom_range(0, 9) != 0) begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
          end
        end
        default: radix = 10;
      endcase
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(16, (radix == 2) ? 70 : 24)
                                         : $urandom_range(0, 12);
      repeat (ndig) text.push_back(rand_digit(radix));
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 5)) text.push_back(rand_junk());
      end
    end
    text.push_back(CH_NUL);
    foreach (text[i]) send_byte(text[i]);
  endtask

  // Decimal after reset: the extremes of the value, wrapping past 2^64,
  // every whitespace code, both signs, a minus before a plus, whitespace after
  // a sign, and strings with no digits at all.
  task automatic test_decimal_defaults();
    send_text("0", 1'b1);
    send_text("9223372036854775807", 1'b1);
    send_text("-9223372036854775808", 1'b1);
    send_text("18446744073709551617", 1'b1);
    send_text(" \t\n\013\014\r7", 1'b1);
    send_text("  +-42z tail", 1'b1);
    send_text("+", 1'b1);
    send_text("-+5", 1'b1);
    send_text("- 5", 1'b1);
    send_text("", 1'b1);
  endtask

  // Hex needs its prefix; auto mode tells hex, binary and decimal apart by
  // the leading bytes; binary stops at the first digit above one; any other
  // base_select value yields zero at offset zero.
  task automatic test_base_modes();
    write_base(BSEL_HEX);
    send_text("0xFFFFffffFFFFFFFF", 1'b1);
    send_text("-0XdeadBEEF9", 1'b1);
    send_text("1f", 1'b1);
    send_text("0q", 1'b1);
    send_text("0x", 1'b1);
    write_base(BSEL_AUTO);
    send_text("0x1F", 1'b1);
    send_text("0101", 1'b1);
    send_text("077", 1'b1);
    send_text("-123", 1'b1);
    send_text("x", 1'b1);
    write_base(BSEL_BIN);
    send_text("1012", 1'b1);
    send_text("-11", 1'b1);
    write_base(8'd255);
    send_text(" 5", 1'b1);
    write_base(8'd1);
    send_text("", 1'b1);
  endtask

  // The base is taken when the body starts: a write that lands in the middle
  // of a string changes nothing until the next string.
  task automatic test_base_latch();
    write_base(BSEL_DEC);
    send_text("12", 1'b0);
    write_base(BSEL_HEX);
    send_text("3f", 1'b1);
    send_text("0x1f", 1'b1);
  endtask

  // Random strings in phases with different bases and different mixes of
  // idling on the two sides. Now and then the sender holds off until every
  // number has come out.
  task automatic test_random_traffic();
    logic [7:0] bases[8];
    int         target;
    bases = '{BSEL_AUTO, BSEL_DEC, BSEL_HEX, BSEL_BIN,
              ODD_BASES[$urandom_range(0, 4)], BSEL_HEX, BSEL_AUTO, BSEL_DEC};
    foreach (bases[i]) begin
      write_base(bases[i]);
      tx_gaps_on = (i % 4 == 0) || (i % 4 == 2);
      rx_stalls_on = (i % 4 == 0) || (i % 4 == 3);
      target = live_bytes + 50;
      while (live_bytes < target) begin
        send_random_string();
        if ($urandom_range(0, 14) == 0) wait_for_results();
      end
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_decimal_defaults();
    test_base_modes();
    test_base_latch();
    test_random_traffic();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (parsed_numbers.size() != 0) begin
      $display("%0t: %0d expected results never arrived",
               $realtime, parsed_numbers.size());
      errors++;
    end
    if (errors == 0) begin
      $display("string_to_int64_parser test passed");
    end else begin
      $display("string_to_int64_parser test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even with every gap and stall long.
  initial begin
    #20000000;
    $display("string_to_int64_parser test failed");
    $finish;
  end

endmodule
